// ----- rtl/chs_pkg.sv -----
package chs_pkg;

   localparam int MAX_BINS_DEFAULT = 16;
   localparam int CNT_W = 32;
   localparam int PIX_W = 8;
   localparam int RIDX_W = 4;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = 5;
   localparam int SUM_W = 10;
   localparam int QUO_W = 5;
   localparam int NUM_W = 13;

   typedef enum logic [1:0] {
      OP_ACCUM = 2'd0,
      OP_READ  = 2'd1,
      OP_CLEAR = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   localparam logic [CSR_IDX_W-1:0] CSR_BINS  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SPLAT = 1'd1;

   typedef struct packed {
      op_type            op;
      logic [PIX_W-1:0]  red;
      logic [PIX_W-1:0]  green;
      logic [PIX_W-1:0]  blue;
      logic [RIDX_W-1:0] read_row;
      logic [RIDX_W-1:0] read_col;
   } req_type;

   typedef struct packed {
      logic [CNT_W-1:0] bin_count;
   } rsp_type;

endpackage

// ----- rtl/chs_stream_if.sv -----
interface chs_stream_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ----- rtl/chromaticity_histogram_splat_top.sv -----
// rg chromaticity histogram. Commands arrive on req_ (op: accumulate pixel,
// read one bin, clear all bins); a read returns one saturated 32-bit count on
// rsp_, other commands return nothing. The counts live in one synchronous
// memory of MAX_BINS*MAX_BINS words with one read and one write port. A pixel
// first passes a restoring divider (one quotient bit per cycle for row and
// column at once), then each kernel cell on the grid passes a read state and
// a write state, a cell off the grid only the read state; req ready stays low
// until the last cell is done. A read holds the block until rsp_ is taken. A
// clear sweeps the memory, one word a cycle; the same sweep runs after reset
// before the first item is accepted.
module chromaticity_histogram_splat_top #(
   parameter int MAX_BINS = chs_pkg::MAX_BINS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   chs_stream_if.sink                     req,
   chs_stream_if.source                   rsp,
   input  logic                           csr_write_enable,
   input  logic [chs_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [chs_pkg::CSR_DATA_W-1:0] csr_write_data
);
   import chs_pkg::*;

   localparam int DEPTH = MAX_BINS * MAX_BINS;
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int BW = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
   localparam int CW = BW + 1;
   localparam int DCW = $clog2(SUM_W + 1);

   typedef enum logic [5:0] {
      ST_CLEAR = 6'b000001,
      ST_IDLE  = 6'b000010,
      ST_DIV   = 6'b000100,
      ST_RD    = 6'b001000,
      ST_WR    = 6'b010000,
      ST_RSP   = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic [CSR_DATA_W-1:0] bins_cfg_ff;
   logic splat_ff;

   logic [CNT_W-1:0] mem [DEPTH];
   logic [CNT_W-1:0] rdata_ff;
   logic             mem_we;
   logic [AW-1:0]    mem_wa, mem_ra;
   logic [CNT_W-1:0] mem_wd;

   logic [AW:0]  clr_ff, clr_in;
   logic [NUM_W-1:0] rrem_ff, rrem_in, grem_ff, grem_in;
   logic [NUM_W-1:0] rnum_ff, rnum_in, gnum_ff, gnum_in;
   logic [QUO_W-1:0] rq_ff, rq_in, gq_ff, gq_in;
   logic [SUM_W-1:0] den_ff, den_in;
   logic [DCW-1:0]   dcnt_ff, dcnt_in;
   logic [1:0] dr_ff, dr_in, dc_ff, dc_in;
   logic [1:0] rd_ok_ff, rd_ok_in;
   logic [AW-1:0] addr_ff, addr_in;
   logic [CNT_W-1:0] rsp_ff, rsp_in;

   logic [QUO_W-1:0] bins_use;
   logic [CW:0] nr, nc;
   logic cell_ok;
   logic [2:0] wgt;
   logic [CNT_W:0] sum;
   logic last_cell;
   logic [NUM_W-1:0] rs, gs;
   logic [NUM_W:0] rdiff, gdiff;

   always_comb begin
      bins_use = bins_cfg_ff;
      if (bins_cfg_ff == '0) bins_use = QUO_W'(1);
      if (32'(bins_cfg_ff) > MAX_BINS) bins_use = QUO_W'(MAX_BINS);
   end

   // kernel cell position: center + (dr-1, dc-1); plain mode uses center only
   always_comb begin
      nr = (CW+1)'(rq_ff) + (CW+1)'(dr_ff) - (CW+1)'(1);
      nc = (CW+1)'(gq_ff) + (CW+1)'(dc_ff) - (CW+1)'(1);
      cell_ok = !nr[CW] && !nc[CW] && (32'(nr) < 32'(bins_use))
                && (32'(nc) < 32'(bins_use));
      wgt = 3'd1;
      if (splat_ff) begin
         wgt = 3'd1 << ((dr_ff == 2'd1 ? 1 : 0) + (dc_ff == 2'd1 ? 1 : 0));
      end
      last_cell = !splat_ff || (dr_ff == 2'd2 && dc_ff == 2'd2);
      sum = {1'b0, rdata_ff} + (CNT_W+1)'(wgt);
   end

   always_comb begin
      rs = {rrem_ff[NUM_W-2:0], rnum_ff[NUM_W-1]};
      gs = {grem_ff[NUM_W-2:0], gnum_ff[NUM_W-1]};
      rdiff = {1'b0, rs} - (NUM_W+1)'(den_ff);
      gdiff = {1'b0, gs} - (NUM_W+1)'(den_ff);
   end

   always_comb begin
      state_in = state_ff;
      clr_in = clr_ff;
      rrem_in = rrem_ff; grem_in = grem_ff;
      rnum_in = rnum_ff; gnum_in = gnum_ff;
      rq_in = rq_ff; gq_in = gq_ff;
      den_in = den_ff; dcnt_in = dcnt_ff;
      dr_in = dr_ff; dc_in = dc_ff;
      rd_ok_in = rd_ok_ff;
      addr_in = addr_ff;
      rsp_in = rsp_ff;
      mem_we = 1'b0;
      mem_wa = addr_ff;
      mem_wd = '0;
      mem_ra = addr_ff;
      req.ready = (state_ff == ST_IDLE);
      case (state_ff)
         ST_CLEAR: begin
            mem_we = 1'b1;
            mem_wa = clr_ff[AW-1:0];
            clr_in = clr_ff + 1'b1;
            if (32'(clr_ff) == DEPTH - 1) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req.valid) begin
               case (req.payload.op)
                  OP_ACCUM: begin
                     rnum_in = NUM_W'(req.payload.red) * NUM_W'(bins_use);
                     gnum_in = NUM_W'(req.payload.green) * NUM_W'(bins_use);
                     den_in = SUM_W'(req.payload.red) + SUM_W'(req.payload.green)
                              + SUM_W'(req.payload.blue) + SUM_W'(1);
                     rrem_in = '0; grem_in = '0; rq_in = '0; gq_in = '0;
                     dcnt_in = '0;
                     state_in = ST_DIV;
                  end
                  OP_READ: begin
                     rd_ok_in = '0;
                     if (32'(req.payload.read_row) < MAX_BINS
                         && 32'(req.payload.read_col) < MAX_BINS) begin
                        rd_ok_in = 2'd1;
                     end
                     addr_in = AW'(32'(req.payload.read_row) * MAX_BINS
                                   + 32'(req.payload.read_col));
                     // start the read now so the data is there next cycle
                     mem_ra = addr_in;
                     state_in = ST_RSP;
                     rd_ok_in[1] = 1'b1;
                  end
                  OP_CLEAR: begin
                     clr_in = '0;
                     state_in = ST_CLEAR;
                  end
                  default: ;
               endcase
            end
         end
         ST_DIV: begin
            // the quotient fits in QUO_W bits; keep only its low bits
            rrem_in = rdiff[NUM_W] ? rs : rdiff[NUM_W-1:0];
            grem_in = gdiff[NUM_W] ? gs : gdiff[NUM_W-1:0];
            rq_in = {rq_ff[QUO_W-2:0], !rdiff[NUM_W]};
            gq_in = {gq_ff[QUO_W-2:0], !gdiff[NUM_W]};
            rnum_in = rnum_ff << 1;
            gnum_in = gnum_ff << 1;
            dcnt_in = dcnt_ff + 1'b1;
            if (32'(dcnt_ff) == NUM_W - 1) begin
               dr_in = splat_ff ? 2'd0 : 2'd1;
               dc_in = splat_ff ? 2'd0 : 2'd1;
               state_in = ST_RD;
            end
         end
         ST_RD: begin
            // issue read; skip cells off the grid
            mem_ra = AW'(32'(nr[BW-1:0]) * MAX_BINS + 32'(nc[BW-1:0]));
            addr_in = mem_ra;
            if (cell_ok) begin
               state_in = ST_WR;
            end else if (last_cell) begin
               state_in = ST_IDLE;
            end else begin
               dc_in = (dc_ff == 2'd2) ? 2'd0 : dc_ff + 2'd1;
               if (dc_ff == 2'd2) dr_in = dr_ff + 2'd1;
            end
         end
         ST_WR: begin
            mem_we = 1'b1;
            mem_wd = sum[CNT_W] ? '1 : sum[CNT_W-1:0];
            if (last_cell) begin
               state_in = ST_IDLE;
            end else begin
               state_in = ST_RD;
               dc_in = (dc_ff == 2'd2) ? 2'd0 : dc_ff + 2'd1;
               if (dc_ff == 2'd2) dr_in = dr_ff + 2'd1;
            end
         end
         ST_RSP: begin
            // first cycle loads data, then hold until taken
            if (rd_ok_ff[1]) begin
               rd_ok_in[1] = 1'b0;
               rsp_in = rd_ok_ff[0] ? rdata_ff : '0;
            end else if (rsp.ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp.valid = (state_ff == ST_RSP) && !rd_ok_ff[1];
   assign rsp.payload.bin_count = rsp_ff;

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_wa] <= mem_wd;
      rdata_ff <= mem[mem_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff <= '0;
         bins_cfg_ff <= CSR_DATA_W'(16);
         splat_ff <= 1'b0;
         rd_ok_ff <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         rd_ok_ff <= rd_ok_in;
         if (csr_write_enable) begin
            case (csr_index)
               CSR_BINS:  bins_cfg_ff <= csr_write_data;
               CSR_SPLAT: splat_ff <= csr_write_data[0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      rrem_ff <= rrem_in; grem_ff <= grem_in;
      rnum_ff <= rnum_in; gnum_ff <= gnum_in;
      rq_ff <= rq_in; gq_ff <= gq_in;
      den_ff <= den_in; dcnt_ff <= dcnt_in;
      dr_ff <= dr_in; dc_ff <= dc_in;
      addr_ff <= addr_in;
      rsp_ff <= rsp_in;
   end

endmodule

// ----- dv/chromaticity_histogram_splat_top_tb.sv -----
`timescale 1ns / 1ps

module chromaticity_histogram_splat_top_tb;
   import chs_pkg::*;

   localparam int NBINS = MAX_BINS_DEFAULT;
   localparam int LIMIT = 2000000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_write_data = '0;

   chs_stream_if #(.payload_type(req_type)) req_ch ();
   chs_stream_if #(.payload_type(rsp_type)) rsp_ch ();

   chromaticity_histogram_splat_top dut (
      .clock(clock),
      .reset(reset),
      .req(req_ch.sink),
      .rsp(rsp_ch.source),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // predicted histogram and settings
   logic [CNT_W-1:0] hist_model [NBINS*NBINS];
   logic [4:0] model_bins;
   logic model_splat;

   req_type pixel_queue [$];
   logic [CNT_W-1:0] count_queue [$];
   int mismatches = 0;
   int cycles = 0;
   bit calm = 1'b0;
   bit feed_on = 1'b0;

   function automatic void add_pending(req_type it);
      pixel_queue.insert(pixel_queue.size(), it);
   endfunction

   function automatic void bump_bin(int r, int c, logic [CNT_W-1:0] amt);
      logic [CNT_W-1:0] cur;
      cur = hist_model[r*NBINS+c];
      if (32'hFFFF_FFFF - cur < amt) hist_model[r*NBINS+c] = 32'hFFFF_FFFF;
      else hist_model[r*NBINS+c] = cur + amt;
   endfunction

   function automatic void predict_item(req_type it);
      int nb, den, row, col, nr, nc, w;
      case (it.op)
         OP_ACCUM: begin
            nb = int'(model_bins);
            if (nb == 0) nb = 1;
            if (nb > NBINS) nb = NBINS;
            den = int'(it.red) + int'(it.green) + int'(it.blue) + 1;
            row = (int'(it.red) * nb) / den;
            col = (int'(it.green) * nb) / den;
            if (!model_splat) bump_bin(row, col, CNT_W'(1));
            else begin
               for (int dr = -1; dr <= 1; dr++)
                  for (int dc = -1; dc <= 1; dc++) begin
                     nr = row + dr;
                     nc = col + dc;
                     w = (dr == 0 ? 2 : 1) * (dc == 0 ? 2 : 1);
                     if (nr >= 0 && nc >= 0 && nr < nb && nc < nb)
                        bump_bin(nr, nc, CNT_W'(w));
                  end
            end
         end
         OP_READ: count_queue.insert(count_queue.size(),
                                     hist_model[int'(it.read_row)*NBINS+int'(it.read_col)]);
         OP_CLEAR: for (int i = 0; i < NBINS*NBINS; i++) hist_model[i] = '0;
         default: ;
      endcase
   endfunction

   // driver
   initial begin
      req_ch.valid = 1'b0;
      req_ch.payload = '0;
      rsp_ch.ready = 1'b0;
   end

   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            predict_item(req_ch.payload);
            void'(pixel_queue.pop_front());
         end
         if (req_ch.valid && !req_ch.ready) begin
            // hold
         end else if (feed_on && pixel_queue.size() > (req_ch.valid && req_ch.ready)
                      && (calm || $urandom_range(99) >= 14)) begin
            req_ch.valid <= 1'b1;
            req_ch.payload <= pixel_queue[(req_ch.valid && req_ch.ready) ? 1 : 0];
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset) begin
         rsp_ch.ready <= calm || $urandom_range(99) >= 14;
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (count_queue.size() == 0) begin
               mismatches = mismatches + 1;
               if (mismatches <= 10) $display("unexpected item: bin_count %h",
                                              rsp_ch.payload.bin_count);
            end else begin
               if (rsp_ch.payload.bin_count !== count_queue[0]) begin
                  mismatches = mismatches + 1;
                  if (mismatches <= 10) $display("bin_count mismatch: exp %h got %h",
                                                 count_queue[0], rsp_ch.payload.bin_count);
               end
               void'(count_queue.pop_front());
            end
         end
      end
      if (cycles > LIMIT) begin
         $display("chromaticity_histogram_splat_top_tb NOT OK");
         $finish;
      end
   end

   function automatic req_type rand_item(int read_pct);
      req_type it;
      int k;
      it = '0;
      it.red = PIX_W'($urandom);
      it.green = PIX_W'($urandom);
      it.blue = PIX_W'($urandom);
      it.read_row = RIDX_W'($urandom);
      it.read_col = RIDX_W'($urandom);
      k = $urandom_range(99);
      if (k < read_pct) it.op = OP_READ;
      else if (k < read_pct + 2) it.op = OP_CLEAR;
      else if (k < read_pct + 4) it.op = OP_NONE;
      else it.op = OP_ACCUM;
      if ($urandom_range(9) == 0) it.blue = '0;
      if ($urandom_range(9) == 0) begin
         it.red = 8'd255;
         it.green = '0;
      end
      return it;
   endfunction

   function automatic req_type make_item(op_type op, int r, int g, int b, int rr, int rc);
      req_type it;
      it.op = op;
      it.red = PIX_W'(r);
      it.green = PIX_W'(g);
      it.blue = PIX_W'(b);
      it.read_row = RIDX_W'(rr);
      it.read_col = RIDX_W'(rc);
      return it;
   endfunction

   task automatic drain();
      while (pixel_queue.size() != 0 || req_ch.valid || count_queue.size() != 0)
         @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [4:0] val);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= val;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      if (idx == CSR_BINS) model_bins = val;
      else model_splat = val[0];
   endtask

   task automatic read_all();
      for (int r = 0; r < NBINS; r++)
         for (int c = 0; c < NBINS; c++)
            add_pending(make_item(OP_READ, 0, 0, 0, r, c));
   endtask

   logic [4:0] bin_choices [6] = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd5, 5'd2};

   initial begin
      for (int i = 0; i < NBINS*NBINS; i++) hist_model[i] = '0;
      model_bins = 5'd16;
      model_splat = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      feed_on = 1'b1;
      // directed: corners, zero pixel, unused op, clear
      add_pending(make_item(OP_ACCUM, 0, 0, 0, 0, 0));
      add_pending(make_item(OP_ACCUM, 255, 0, 0, 0, 0));
      add_pending(make_item(OP_ACCUM, 0, 255, 0, 0, 0));
      add_pending(make_item(OP_ACCUM, 255, 255, 255, 15, 15));
      add_pending(make_item(OP_NONE, 255, 255, 0, 0, 0));
      add_pending(make_item(OP_READ, 0, 0, 0, 0, 0));
      add_pending(make_item(OP_READ, 0, 0, 0, 15, 0));
      add_pending(make_item(OP_READ, 0, 0, 0, 0, 15));
      add_pending(make_item(OP_READ, 255, 255, 255, 5, 5));
      add_pending(make_item(OP_CLEAR, 255, 255, 255, 15, 15));
      add_pending(make_item(OP_READ, 0, 0, 0, 0, 0));
      drain();
      write_csr(CSR_SPLAT, 5'd1);
      add_pending(make_item(OP_ACCUM, 0, 0, 0, 0, 0));
      add_pending(make_item(OP_ACCUM, 255, 0, 0, 0, 0));
      add_pending(make_item(OP_ACCUM, 0, 255, 0, 0, 0));
      add_pending(make_item(OP_ACCUM, 128, 64, 10, 0, 0));
      read_all();
      drain();
      for (int ph = 0; ph < 6; ph++) begin
         write_csr(CSR_BINS, bin_choices[ph]);
         write_csr(CSR_SPLAT, ph[0] ? 5'd0 : 5'd1);
         calm = (ph == 3);
         for (int n = 0; n < 110; n++) add_pending(rand_item(20));
         drain();
      end
      calm = 1'b0;
      if (mismatches == 0) $display("chromaticity_histogram_splat_top_tb OK");
      else $display("chromaticity_histogram_splat_top_tb NOT OK");
      $finish;
   end

endmodule

// ----- files.f -----
rtl/chs_pkg.sv
rtl/chs_stream_if.sv
rtl/chromaticity_histogram_splat_top.sv
dv/chromaticity_histogram_splat_top_tb.sv
